// ===== rtl/core/c2d_pkg.sv =====
// Shared types, widths and defaults of the replicate-padded convolution block.
package c2d_pkg;

  // Default geometry, handed to the top-level parameters
  localparam int DEF_IN_CH  = 3;
  localparam int DEF_OUT_CH = 64;
  localparam int DEF_KSIZE  = 9;
  localparam int DEF_HEIGHT = 256;
  localparam int DEF_WIDTH  = 256;

  // Fixed field widths of the request and result items
  localparam int OC_W    = 6;
  localparam int ICF_W   = 2;
  localparam int POS_W   = 8;
  localparam int DATA_W  = 16;
  localparam int RES_W   = 31;
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;

  // Address widths that cover the largest legal geometry
  localparam int WA_MAXW = 16;
  localparam int IA_MAXW = 19;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_BIAS   = 2'd1,
    REQ_PIXEL  = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_ISSUE,
    S_DRAIN,
    S_BIAS,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    req_type_t                 typ;
    logic [OC_W-1:0]           oc;
    logic [ICF_W-1:0]          ic;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [DATA_W-1:0]  data;
  } req_t;

  typedef struct packed {
    logic                      w_we;
    logic [WA_MAXW-1:0]        w_waddr;
    logic [WA_MAXW-1:0]        w_raddr;
    logic                      b_we;
    logic [OC_W-1:0]           b_addr;
    logic                      i_we;
    logic [IA_MAXW-1:0]        i_waddr;
    logic [IA_MAXW-1:0]        i_raddr;
    logic signed [DATA_W-1:0]  wdata;
  } store_ctl_t;

  typedef struct packed {
    logic clear;
    logic tap;
    logic bias_add;
  } mac_ctl_t;

  typedef struct packed {
    logic valid;
    logic is_read;
    logic zero;
  } done_t;

endpackage

// ===== rtl/core/c2d_store.sv =====
// Weight, bias and image memories with one write and one registered read each.
module c2d_store #(
  parameter int IN_CH  = c2d_pkg::DEF_IN_CH,
  parameter int OUT_CH = c2d_pkg::DEF_OUT_CH,
  parameter int KSIZE  = c2d_pkg::DEF_KSIZE,
  parameter int HEIGHT = c2d_pkg::DEF_HEIGHT,
  parameter int WIDTH  = c2d_pkg::DEF_WIDTH
) (
  input  logic                              clk,
  input  c2d_pkg::store_ctl_t               st,
  output logic signed [c2d_pkg::DATA_W-1:0] w_rdata,
  output logic signed [c2d_pkg::DATA_W-1:0] b_rdata,
  output logic signed [c2d_pkg::DATA_W-1:0] i_rdata
);
  import c2d_pkg::*;

  localparam int W_DEPTH = OUT_CH * IN_CH * KSIZE * KSIZE;
  localparam int I_DEPTH = IN_CH * HEIGHT * WIDTH;
  localparam int WA_W = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int IA_W = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
  localparam int BA_W = (OUT_CH > 1) ? $clog2(OUT_CH) : 1;

  logic signed [DATA_W-1:0] wmem [W_DEPTH];
  logic signed [DATA_W-1:0] bmem [OUT_CH];
  logic signed [DATA_W-1:0] imem [I_DEPTH];

  // Weight memory
  always_ff @(posedge clk) begin
    if (st.w_we) begin
      wmem[st.w_waddr[WA_W-1:0]] <= st.wdata;
    end
    w_rdata <= wmem[st.w_raddr[WA_W-1:0]];
  end

  // Bias memory, one entry per output channel
  always_ff @(posedge clk) begin
    if (st.b_we) begin
      bmem[st.b_addr[BA_W-1:0]] <= st.wdata;
    end
    b_rdata <= bmem[st.b_addr[BA_W-1:0]];
  end

  // Image memory, all input channels
  always_ff @(posedge clk) begin
    if (st.i_we) begin
      imem[st.i_waddr[IA_W-1:0]] <= st.wdata;
    end
    i_rdata <= imem[st.i_raddr[IA_W-1:0]];
  end

endmodule

// ===== rtl/core/c2d_mac.sv =====
// Shared multiply-accumulate unit with bias add, ReLU and saturation.
module c2d_mac #(
  parameter int IN_CH = c2d_pkg::DEF_IN_CH,
  parameter int KSIZE = c2d_pkg::DEF_KSIZE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  c2d_pkg::mac_ctl_t                 mc,
  input  logic signed [c2d_pkg::DATA_W-1:0] w_rdata,
  input  logic signed [c2d_pkg::DATA_W-1:0] i_rdata,
  input  logic signed [c2d_pkg::DATA_W-1:0] b_rdata,
  output logic [c2d_pkg::RES_W-1:0]         result
);
  import c2d_pkg::*;

  localparam int TAPS  = IN_CH * KSIZE * KSIZE;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W = PROD_W + 1 + ((TAPS > 1) ? $clog2(TAPS) : 1);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  logic signed [ACC_W-1:0]  acc;

  // Register the product, then fold it into the sum
  always_ff @(posedge clk) begin
    prod <= w_rdata * i_rdata;
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= mc.tap;
    end
  end

  always_ff @(posedge clk) begin
    if (mc.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end else if (mc.bias_add) begin
      acc <= acc + ACC_W'(b_rdata);
    end
  end

  // Clip negative sums to zero, large sums to the positive maximum
  always_comb begin
    if (acc[ACC_W-1]) begin
      result = '0;
    end else if (|acc[ACC_W-2:RES_W]) begin
      result = '1;
    end else begin
      result = acc[RES_W-1:0];
    end
  end

  a_bias_after_drain: assert property (@(posedge clk) disable iff (rst)
    mc.bias_add |-> !prod_v)
    else $error("bias add overlaps a pending product");

  a_clear_not_tap: assert property (@(posedge clk) disable iff (rst)
    mc.clear |-> !mc.tap)
    else $error("accumulator clear during a tap");

endmodule

// ===== rtl/core/c2d_seq.sv =====
// Request sequencer: store writes, tap counters, clamped addresses, drain timing.
module c2d_seq #(
  parameter int IN_CH  = c2d_pkg::DEF_IN_CH,
  parameter int OUT_CH = c2d_pkg::DEF_OUT_CH,
  parameter int KSIZE  = c2d_pkg::DEF_KSIZE,
  parameter int HEIGHT = c2d_pkg::DEF_HEIGHT,
  parameter int WIDTH  = c2d_pkg::DEF_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  c2d_pkg::req_t       in_req,
  input  logic                out_free,
  output c2d_pkg::store_ctl_t st,
  output c2d_pkg::mac_ctl_t   mc,
  output c2d_pkg::done_t      done
);
  import c2d_pkg::*;

  localparam int TAPS = IN_CH * KSIZE * KSIZE;
  localparam int KK   = KSIZE * KSIZE;
  localparam int HW   = HEIGHT * WIDTH;
  localparam int PAD  = KSIZE / 2;
  localparam int IC_W = (IN_CH > 1) ? $clog2(IN_CH) : 1;
  localparam int K_W  = (KSIZE > 1) ? $clog2(KSIZE) : 1;
  localparam int DRAIN_LEN = 3;
  localparam int SP_W = POS_W + 2;

  seq_state_t         state, state_next;
  req_t               req;
  logic [IC_W-1:0]    ic_cnt;
  logic [K_W-1:0]     kr_cnt;
  logic [K_W-1:0]     kc_cnt;
  logic [WA_MAXW-1:0] wa;
  logic [WA_MAXW-1:0] w_ra;
  logic [IA_MAXW-1:0] i_ra;
  logic               addr_v;
  logic               rd_v;
  logic [1:0]         drain_cnt;

  logic               in_accept;
  logic               last_tap;
  logic               kc_end;
  logic               kr_end;
  logic               rd_ok;
  logic [SP_W-1:0]    rs;
  logic [SP_W-1:0]    cs;
  logic [POS_W-1:0]   r_cl;
  logic [POS_W-1:0]   c_cl;
  logic [IA_MAXW-1:0] i_ra_next;

  assign in_accept = in_valid && in_ready;
  assign kc_end    = (kc_cnt == K_W'(KSIZE - 1));
  assign kr_end    = (kr_cnt == K_W'(KSIZE - 1));
  assign last_tap  = kc_end && kr_end && (ic_cnt == IC_W'(IN_CH - 1));
  assign rd_ok     = (req.typ == REQ_READ) && (int'(req.oc) < OUT_CH);

  // Clamp the tap position into the image (edge replicate)
  always_comb begin
    rs = SP_W'(req.row) + SP_W'(kr_cnt) - SP_W'(PAD);
    cs = SP_W'(req.col) + SP_W'(kc_cnt) - SP_W'(PAD);
    if (rs[SP_W-1]) begin
      r_cl = '0;
    end else if (rs > SP_W'(HEIGHT - 1)) begin
      r_cl = POS_W'(HEIGHT - 1);
    end else begin
      r_cl = rs[POS_W-1:0];
    end
    if (cs[SP_W-1]) begin
      c_cl = '0;
    end else if (cs > SP_W'(WIDTH - 1)) begin
      c_cl = POS_W'(WIDTH - 1);
    end else begin
      c_cl = cs[POS_W-1:0];
    end
    i_ra_next = IA_MAXW'(ic_cnt * HW + r_cl * WIDTH + c_cl);
  end

  // Store controls: writes from the held request, reads from the tap pipeline
  always_comb begin
    st.wdata   = req.data;
    st.b_addr  = req.oc;
    st.w_raddr = w_ra;
    st.i_raddr = i_ra;
    st.w_waddr = WA_MAXW'(req.oc * TAPS + req.ic * KK + req.row * KSIZE + req.col);
    st.i_waddr = IA_MAXW'(req.ic * HW + req.row * WIDTH + req.col);
    st.w_we    = (state == S_WRITE) && (req.typ == REQ_WEIGHT) &&
                 (int'(req.oc) < OUT_CH) && (int'(req.ic) < IN_CH) &&
                 (int'(req.row) < KSIZE) && (int'(req.col) < KSIZE);
    st.b_we    = (state == S_WRITE) && (req.typ == REQ_BIAS) &&
                 (int'(req.oc) < OUT_CH);
    st.i_we    = (state == S_WRITE) && (req.typ == REQ_PIXEL) &&
                 (int'(req.ic) < IN_CH) && (int'(req.row) < HEIGHT) &&
                 (int'(req.col) < WIDTH);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    done.valid   = 1'b0;
    done.is_read = (req.typ == REQ_READ);
    done.zero    = !rd_ok;
    mc.clear     = in_accept;
    mc.tap       = rd_v;
    mc.bias_add  = (state == S_BIAS);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req.typ != REQ_READ) begin
            state_next = S_WRITE;
          end else if (int'(in_req.oc) < OUT_CH) begin
            state_next = S_ISSUE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_WRITE: state_next = S_FINISH;
      S_ISSUE: begin
        if (last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_cnt == 2'(DRAIN_LEN - 1)) begin
          state_next = S_BIAS;
        end
      end
      S_BIAS: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          done.valid = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold the request and step the tap counters
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req    <= in_req;
      ic_cnt <= '0;
      kr_cnt <= '0;
      kc_cnt <= '0;
      wa     <= WA_MAXW'(in_req.oc * TAPS);
    end else if (state == S_ISSUE) begin
      wa <= wa + 1'b1;
      if (kc_end) begin
        kc_cnt <= '0;
        if (kr_end) begin
          kr_cnt <= '0;
          ic_cnt <= ic_cnt + 1'b1;
        end else begin
          kr_cnt <= kr_cnt + 1'b1;
        end
      end else begin
        kc_cnt <= kc_cnt + 1'b1;
      end
    end
    w_ra <= wa;
    i_ra <= i_ra_next;
  end

  // Track taps in flight and count the drain
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_v    <= 1'b0;
      rd_v      <= 1'b0;
      drain_cnt <= '0;
    end else begin
      addr_v <= (state == S_ISSUE);
      rd_v   <= addr_v;
      if (state == S_DRAIN) begin
        drain_cnt <= drain_cnt + 1'b1;
      end else begin
        drain_cnt <= '0;
      end
    end
  end

  a_addr_from_issue: assert property (@(posedge clk) disable iff (rst)
    addr_v |-> $past(state == S_ISSUE))
    else $error("tap address valid without an issue cycle");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> !(st.w_we || st.b_we || st.i_we))
    else $error("store write during a read sweep");

  a_read_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_req.typ == REQ_READ) && (int'(in_req.oc) < OUT_CH))
      |=> (state == S_ISSUE))
    else $error("read of a valid channel did not start the sweep");

endmodule

// ===== rtl/core/conv2d_replicate_pad_bias_relu.sv =====
// Top level of the on-request 2-D convolution with replicate padding, bias and ReLU.
//
// Usage:
//   Requests arrive on the s_axis channel, one per transfer. s_axis_tuser
//   carries the request kind (weight, bias, pixel write, or read). Writes
//   fill the weight, bias and image memories; a read names an output
//   channel, row and column and returns one output pixel.
//   Every request returns exactly one transfer on m_axis: writes answer
//   zero with m_axis_tuser low, reads answer the clipped result (zero for
//   an output channel out of range) with m_axis_tuser high.
//   During a read the shared multiply-accumulate unit consumes one tap
//   per cycle, fed by one read port on each memory; then the sequencer
//   waits in its drain state while the address, read and multiply stages
//   empty, and the bias state adds the bias.
//   s_axis_tready is high only while the sequencer is idle. A finished
//   result sits in the output register; while the receiver stalls, the
//   block still takes the next request and holds its own result back.
//   Reset clears the control state only; memory contents stay undefined
//   until written.
module conv2d_replicate_pad_bias_relu #(
  parameter int IN_CH  = c2d_pkg::DEF_IN_CH,
  parameter int OUT_CH = c2d_pkg::DEF_OUT_CH,
  parameter int KSIZE  = c2d_pkg::DEF_KSIZE,
  parameter int HEIGHT = c2d_pkg::DEF_HEIGHT,
  parameter int WIDTH  = c2d_pkg::DEF_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // out_chan[5:0], in_chan[7:6], row_pos[15:8], col_pos[23:16], data_value[39:24]
  input  logic [c2d_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // req_type[1:0]
  input  logic [c2d_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_value[30:0], zero fill [31]
  output logic [c2d_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // is_read[0]
  output logic                            m_axis_tuser
);
  import c2d_pkg::*;

  req_t                     in_req;
  store_ctl_t               st;
  mac_ctl_t                 mc;
  done_t                    done;
  logic                     out_free;
  logic signed [DATA_W-1:0] w_rdata;
  logic signed [DATA_W-1:0] b_rdata;
  logic signed [DATA_W-1:0] i_rdata;
  logic [RES_W-1:0]         mac_res;
  logic [RES_W-1:0]         res;
  logic                     res_read;

  // Unpack the request fields
  always_comb begin
    in_req.typ  = req_type_t'(s_axis_tuser);
    in_req.oc   = s_axis_tdata[5:0];
    in_req.ic   = s_axis_tdata[7:6];
    in_req.row  = s_axis_tdata[15:8];
    in_req.col  = s_axis_tdata[23:16];
    in_req.data = s_axis_tdata[39:24];
  end

  c2d_seq #(
    .IN_CH (IN_CH),
    .OUT_CH(OUT_CH),
    .KSIZE (KSIZE),
    .HEIGHT(HEIGHT),
    .WIDTH (WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_req  (in_req),
    .out_free(out_free),
    .st      (st),
    .mc      (mc),
    .done    (done)
  );

  c2d_store #(
    .IN_CH (IN_CH),
    .OUT_CH(OUT_CH),
    .KSIZE (KSIZE),
    .HEIGHT(HEIGHT),
    .WIDTH (WIDTH)
  ) u_store (
    .clk    (clk),
    .st     (st),
    .w_rdata(w_rdata),
    .b_rdata(b_rdata),
    .i_rdata(i_rdata)
  );

  c2d_mac #(
    .IN_CH(IN_CH),
    .KSIZE(KSIZE)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .mc     (mc),
    .w_rdata(w_rdata),
    .i_rdata(i_rdata),
    .b_rdata(b_rdata),
    .result (mac_res)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Output register: load on completion, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid) begin
      res      <= done.zero ? '0 : mac_res;
      res_read <= done.is_read;
    end
  end

  assign m_axis_tdata = {1'b0, res};
  assign m_axis_tuser = res_read;

  a_write_answers_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("write request answered with a nonzero result");

endmodule

// ===== sim/conv2d_replicate_pad_bias_relu_test.sv =====
// Self-checking testbench of the on-request convolution with replicate padding, bias and ReLU.
module conv2d_replicate_pad_bias_relu_test;
  import c2d_pkg::*;

  localparam int N_IC  = DEF_IN_CH;
  localparam int N_OC  = DEF_OUT_CH;
  localparam int KS    = DEF_KSIZE;
  localparam int IMG_H = DEF_HEIGHT;
  localparam int IMG_W = DEF_WIDTH;
  localparam int PAD   = KS / 2;
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam logic [RES_W-1:0] RES_FULL = '1;

  localparam int N_RANDOM     = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;

  // Two filled image corners; reads stay where every tap lands inside one
  localparam int CORNER  = 9;
  localparam int ROW_FAR = IMG_H - CORNER;
  localparam int COL_FAR = IMG_W - CORNER;

  typedef struct {
    logic [RES_W-1:0] value;
    logic             is_read;
  } conv_result_t;

  typedef struct {
    req_t             req;
    bit               fixed;
    logic [RES_W-1:0] want_value;
    logic             want_read;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  // Shadow copies of the three stores
  logic signed [DATA_W-1:0] weight_mem [N_OC][N_IC][KS][KS];
  logic signed [DATA_W-1:0] bias_mem [N_OC];
  logic signed [DATA_W-1:0] pixel_mem [N_IC][IMG_H][IMG_W];

  conv_result_t pending_results[$];
  int           err_cnt = 0;
  int           idle_cycles = 0;
  bit           steady = 1'b0;
  int           hold_asks = 0;
  int           hold_done = 0;
  int           hold_left = 0;

  conv2d_replicate_pad_bias_relu dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clip_idx(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // One output pixel: full sum over channels and taps, bias, ReLU, saturation
  function automatic logic [RES_W-1:0] conv_at(int oc, int row, int col);
    longint acc;
    int     r;
    int     c;
    acc = 0;
    for (int ic = 0; ic < N_IC; ic++) begin
      for (int kr = 0; kr < KS; kr++) begin
        r = clip_idx(row + kr - PAD, IMG_H - 1);
        for (int kc = 0; kc < KS; kc++) begin
          c = clip_idx(col + kc - PAD, IMG_W - 1);
          acc += longint'(weight_mem[oc][ic][kr][kc]) * longint'(pixel_mem[ic][r][c]);
        end
      end
    end
    acc += longint'(bias_mem[oc]);
    if (acc < 0) acc = 0;
    if (acc > ACC_MAX) acc = ACC_MAX;
    return acc[RES_W-1:0];
  endfunction

  // Apply one request to the shadow stores and return its answer
  function automatic conv_result_t run_request(req_t r);
    conv_result_t res;
    res.value   = '0;
    res.is_read = 1'b0;
    case (r.typ)
      REQ_WEIGHT: begin
        if (int'(r.oc) < N_OC && int'(r.ic) < N_IC && int'(r.row) < KS && int'(r.col) < KS)
          weight_mem[r.oc][r.ic][r.row][r.col] = r.data;
      end
      REQ_BIAS: begin
        if (int'(r.oc) < N_OC) bias_mem[r.oc] = r.data;
      end
      REQ_PIXEL: begin
        if (int'(r.ic) < N_IC && int'(r.row) < IMG_H && int'(r.col) < IMG_W)
          pixel_mem[r.ic][r.row][r.col] = r.data;
      end
      default: begin
        res.is_read = 1'b1;
        if (int'(r.oc) < N_OC) res.value = conv_at(r.oc, r.row, r.col);
      end
    endcase
    return res;
  endfunction

  function automatic req_t mk_req(req_type_t kind, int oc, int ic, int row, int col, int value);
    req_t r;
    r.typ  = kind;
    r.oc   = OC_W'(oc);
    r.ic   = ICF_W'(ic);
    r.row  = POS_W'(row);
    r.col  = POS_W'(col);
    r.data = DATA_W'(value);
    return r;
  endfunction

  // Mostly small codes so sums land mid-range, a third full-scale
  function automatic logic signed [DATA_W-1:0] rand_data();
    if ($urandom_range(2) == 0) return DATA_W'($urandom);
    return DATA_W'(int'($urandom_range(400)) - 200);
  endfunction

  // Offer one request, wait for its transfer, record its answer
  task automatic send_req(input req_t r, input bit fixed = 1'b0,
                          input logic [RES_W-1:0] want_value = '0,
                          input logic want_read = 1'b0);
    conv_result_t pred;
    int           gap;
    gap = (!steady && $urandom_range(99) < 25) ? int'($urandom_range(3, 1)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.data, r.col, r.row, r.ic, r.oc};
    s_axis_tuser  <= r.typ;
    do @(posedge clk); while (!s_axis_tready);
    pred = run_request(r);
    if (fixed) begin
      pred.value   = want_value;
      pred.is_read = want_read;
    end
    pending_results.push_back(pred);
  endtask

  // Receiver: random stalls, a long hold-off on request, none while steady
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_done     <= hold_asks;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 25);
    end
  end

  // Compare each result transfer with the oldest pending answer
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d is_read %0b",
                 $time, m_axis_tdata[RES_W-1:0], m_axis_tuser);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[RES_W-1:0] !== want.value) begin
          $display("%0t: result_value mismatch, expected %0d actual %0d",
                   $time, want.value, m_axis_tdata[RES_W-1:0]);
          err_cnt++;
        end
        if (m_axis_tuser !== want.is_read) begin
          $display("%0t: is_read mismatch, expected %0b actual %0b",
                   $time, want.is_read, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("[conv2d_replicate_pad_bias_relu] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t dir_table[$];
    req_t     r;
    int       pick;
    bit       far;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load opposite full-scale kernels into the two channels that get read
    for (int ic = 0; ic < N_IC; ic++)
      for (int kr = 0; kr < KS; kr++)
        for (int kc = 0; kc < KS; kc++) begin
          send_req(mk_req(REQ_WEIGHT, 0, ic, kr, kc, 32767));
          send_req(mk_req(REQ_WEIGHT, N_OC - 1, ic, kr, kc, -32768));
        end
    send_req(mk_req(REQ_BIAS, 0, 0, 0, 0, 0));
    send_req(mk_req(REQ_BIAS, N_OC - 1, 0, 0, 0, 0));

    // Near corner gets random pixels, far corner full-scale positive
    for (int ic = 0; ic < N_IC; ic++)
      for (int i = 0; i < CORNER; i++)
        for (int j = 0; j < CORNER; j++) begin
          send_req(mk_req(REQ_PIXEL, 0, ic, i, j, rand_data()));
          send_req(mk_req(REQ_PIXEL, 0, ic, ROW_FAR + i, COL_FAR + j, 32767));
        end

    // Directed requests: saturation, ReLU floor, ignored writes, border reads
    dir_table.push_back('{mk_req(REQ_READ, 0, 3, IMG_H-1, IMG_W-1, -1), 1'b1, RES_FULL, 1'b1});
    dir_table.push_back('{mk_req(REQ_READ, N_OC-1, 0, ROW_FAR+PAD, COL_FAR+PAD, 0), 1'b1,
                          '0, 1'b1});
    dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0), 1'b0, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_READ, N_OC-1, 2, PAD, PAD, 32767), 1'b0, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_BIAS, 0, 0, 0, 0, 32767), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_BIAS, N_OC-1, 3, 255, 255, -32768), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_READ, N_OC-1, 1, IMG_H-1, IMG_W-1, 0), 1'b1, '0, 1'b1});
    dir_table.push_back('{mk_req(REQ_READ, 0, 2, ROW_FAR+PAD, COL_FAR+PAD, 0), 1'b1,
                          RES_FULL, 1'b1});
    dir_table.push_back('{mk_req(REQ_WEIGHT, 0, 3, 0, 0, 0), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_WEIGHT, 0, 0, KS, 0, 0), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_WEIGHT, 0, 0, 0, 255, 0), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_WEIGHT, N_OC-1, 2, KS-1, KS-1, 32767), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_PIXEL, 0, 3, 0, 0, 0), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_PIXEL, 63, 2, IMG_H-1, IMG_W-1, -32768), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_PIXEL, 0, 0, 0, 0, 32767), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0), 1'b0, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_READ, N_OC-1, 0, 0, 0, 0), 1'b0, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_READ, N_OC-1, 0, IMG_H-1, IMG_W-1, 0), 1'b0, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_WEIGHT, 0, 1, PAD, PAD, 0), 1'b1, '0, 1'b0});
    dir_table.push_back('{mk_req(REQ_READ, 0, 3, 3, 3, -32768), 1'b0, '0, 1'b0});
    foreach (dir_table[i])
      send_req(dir_table[i].req, dir_table[i].fixed, dir_table[i].want_value,
               dir_table[i].want_read);

    // Random mix of reads and writes over the filled corners, plus stray writes
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 40) hold_asks++;
      if (n == 100) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      steady = (n >= 110 && n < 190);

      pick   = $urandom_range(99);
      far    = $urandom_range(1);
      r      = mk_req(REQ_READ, $urandom, $urandom, $urandom, $urandom, rand_data());
      if (pick < 30) begin
        r.oc  = far ? OC_W'(N_OC - 1) : '0;
        r.row = far ? POS_W'($urandom_range(IMG_H - 1, ROW_FAR + PAD))
                    : POS_W'($urandom_range(CORNER - 1 - PAD));
        r.col = far ? POS_W'($urandom_range(IMG_W - 1, COL_FAR + PAD))
                    : POS_W'($urandom_range(CORNER - 1 - PAD));
        if ($urandom_range(1)) r.oc = (r.oc == '0) ? OC_W'(N_OC - 1) : '0;
      end else if (pick < 62) begin
        r.typ = REQ_PIXEL;
        if ($urandom_range(99) < 85) begin
          r.ic  = ICF_W'($urandom_range(N_IC - 1));
          r.row = POS_W'((far ? ROW_FAR : 0) + int'($urandom_range(CORNER - 1)));
          r.col = POS_W'((far ? COL_FAR : 0) + int'($urandom_range(CORNER - 1)));
        end
      end else if (pick < 85) begin
        r.typ = REQ_WEIGHT;
        if ($urandom_range(99) < 80) r.oc = far ? OC_W'(N_OC - 1) : '0;
        if ($urandom_range(99) >= 8) begin
          r.ic  = ICF_W'($urandom_range(N_IC - 1));
          r.row = POS_W'($urandom_range(KS - 1));
          r.col = POS_W'($urandom_range(KS - 1));
        end
      end else begin
        r.typ = REQ_BIAS;
        if ($urandom_range(99) < 80) r.oc = far ? OC_W'(N_OC - 1) : '0;
      end
      send_req(r);
    end

    // Drain and report
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("[conv2d_replicate_pad_bias_relu] OK");
    else
      $display("[conv2d_replicate_pad_bias_relu] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/c2d_pkg.sv
rtl/core/c2d_store.sv
rtl/core/c2d_mac.sv
rtl/core/c2d_seq.sv
rtl/core/conv2d_replicate_pad_bias_relu.sv
sim/conv2d_replicate_pad_bias_relu_test.sv
